// ===== hw/rtl/ip_mask_filter_table_defines.svh =====
// ----------------------------------------------------------------------------
// Address filter table assertion macros
// Shared assertion shorthands for the filter table, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IP_MASK_FILTER_TABLE_DEFINES_SVH
`define IP_MASK_FILTER_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ipf_pkg.sv =====
// ----------------------------------------------------------------------------
// Address filter table package
// Sizes, request and status codes, payload types and the wildcard mask rule.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned TOTAL_W     = 7;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic               reject;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] entry_total;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] value;
  } entry_t;

  // Every nonzero octet is matched exactly; a zero octet is a wildcard.
  function automatic logic [ADDR_W-1:0] wildcard_mask(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int k = 0; k < ADDR_W / 8; k++) begin
      if (addr[8*k +: 8] != 8'd0) begin
        m[8*k +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/ipf_cell.sv =====
// ----------------------------------------------------------------------------
// Filter table cell
// Holds one mask and value pair and loads its neighbor's pair on each shift.
// ----------------------------------------------------------------------------
module ipf_cell
  import ipf_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      entry_q <= entry_i;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/ipf_chain.sv =====
// ----------------------------------------------------------------------------
// Filter table ring
// A ring of cells that rotates toward the head by one entry per shift; the
// tail cell takes the entry offered by the controller.
// ----------------------------------------------------------------------------
module ipf_chain
  import ipf_pkg::*;
(
  input  logic   clk_i,
  input  logic   shift_i,
  input  entry_t tail_i,
  output entry_t head_o
);

  entry_t link [MAX_ENTRIES];

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    entry_t cell_in;
    if (j == MAX_ENTRIES - 1) begin : g_tail
      assign cell_in = tail_i;
    end else begin : g_mid
      assign cell_in = link[j+1];
    end
    ipf_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .entry_i (cell_in),
      .entry_o (link[j])
    );
  end

  assign head_o = link[0];

endmodule

// ===== hw/rtl/ip_mask_filter_table.sv =====
// ----------------------------------------------------------------------------
// Address filter table
// Mask and value filter table with lookup, add and remove requests.
// ----------------------------------------------------------------------------
// Channel   Signals                          Direction  Handshake
// request   start, busy, req_i               in         start && !busy
// result    result_valid_o, rsp_o            out        one-cycle strobe
// config    cfg_valid_i, cfg_ready_o, cfg_wdata_i  in   valid && ready
//
// Every request rotates the whole entry ring once past the single comparator
// at its head; a remove writes each entry back one slot late until it drops
// the matching one. The result strobe comes in the cycle after the last
// rotation, and a new request may be accepted in that same cycle.
// Reset clears the entry count and sets reject_on_match; entries need no
// clearing. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`include "ip_mask_filter_table_defines.svh"

module ip_mask_filter_table
  import ipf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic result_valid_o,
  output rsp_t rsp_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_wdata_i
);

  state_e            state_q, state_d;
  logic [1:0]        req_q;
  logic [ADDR_W-1:0] addr_q, mask_q;
  logic [CNT_W-1:0]  k_q, k_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic              found_q, found_d;
  logic              hit_q, hit_d;
  logic              append_q, append_d;
  logic              rom_q;
  logic              valid_q, valid_d;
  rsp_t              rsp_q, rsp_d;
  entry_t            hold_q;

  entry_t head, tail, new_entry;
  logic   accept, shift, in_use;
  logic   hit_now, add_take, rem_take, found_any, hit_any, append_any, last;

  assign accept    = start && !busy;
  assign shift     = (state_q == ST_SCAN);
  assign new_entry = '{mask: mask_q, value: addr_q & mask_q};
  assign in_use    = (k_q < used_q);

  assign hit_now  = (req_q == REQ_LOOKUP) && in_use && ((addr_q & head.mask) == head.value);
  assign add_take = (req_q == REQ_ADD) && !found_q &&
                    ((in_use && (head.value == '1)) || (k_q == used_q));
  assign rem_take = (req_q == REQ_REMOVE) && !found_q && in_use && (head == new_entry);
  assign tail     = add_take ? new_entry :
                    ((req_q == REQ_REMOVE) && !found_q) ? hold_q : head;

  assign found_any  = found_q || add_take || rem_take;
  assign hit_any    = hit_q || hit_now;
  assign append_any = append_q || (add_take && (k_q == used_q));
  assign last       = (k_q == CNT_W'(MAX_ENTRIES)) ||
                      ((k_q == CNT_W'(MAX_ENTRIES - 1)) && (req_q != REQ_REMOVE));

  ipf_chain u_chain (
    .clk_i   (clk_i),
    .shift_i (shift),
    .tail_i  (tail),
    .head_o  (head)
  );

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    used_d   = used_q;
    found_d  = found_q;
    hit_d    = hit_q;
    append_d = append_q;
    valid_d  = 1'b0;
    rsp_d    = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_SCAN;
          k_d      = '0;
          found_d  = 1'b0;
          hit_d    = 1'b0;
          append_d = 1'b0;
        end
      end
      ST_SCAN: begin
        k_d      = k_q + CNT_W'(1);
        found_d  = found_any;
        hit_d    = hit_any;
        append_d = append_any;
        if (last) begin
          state_d           = ST_IDLE;
          valid_d           = 1'b1;
          rsp_d.reject      = 1'b0;
          rsp_d.status      = STATUS_DONE;
          case (req_q)
            REQ_LOOKUP: rsp_d.reject = hit_any ? rom_q : !rom_q;
            REQ_ADD: begin
              if (!found_any) begin
                rsp_d.status = STATUS_FULL;
              end else if (append_any) begin
                used_d = used_q + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              if (!found_any) begin
                rsp_d.status = STATUS_NOT_FOUND;
              end else begin
                used_d = used_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
          rsp_d.entry_total = TOTAL_W'(used_d);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      k_q      <= '0;
      used_q   <= '0;
      found_q  <= 1'b0;
      hit_q    <= 1'b0;
      append_q <= 1'b0;
      valid_q  <= 1'b0;
      rom_q    <= 1'b1;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      used_q   <= used_d;
      found_q  <= found_d;
      hit_q    <= hit_d;
      append_q <= append_d;
      valid_q  <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rom_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    hold_q <= head;
    if (accept) begin
      req_q  <= req_i.req_type;
      addr_q <= req_i.address;
      mask_q <= wildcard_mask(req_i.address);
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;
  assign cfg_ready_o    = 1'b1;

  `IPF_ASSERT_NOW(a_result_when_idle, result_valid_o, !busy, "result strobe while busy")
  `IPF_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "request accepted but not busy")
  `IPF_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe too long")
  `IPF_ASSERT_NOW(a_full_at_max, result_valid_o && (rsp_o.status == STATUS_FULL),
                  rsp_o.entry_total == TOTAL_W'(MAX_ENTRIES), "full reported below capacity")

endmodule

// ===== verif/ip_mask_filter_table_tb.sv =====
// ----------------------------------------------------------------------------
// Address filter table testbench
// Walks a short table of directed requests, then streams random lookup, add,
// remove and reserved requests in segments that fill and drain the table.
// Each result is compared field by field against a typed row's response or an
// in-bench model of the mask and value table. The ban mode changes only at a
// directed row and between segments, while the table is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ip_mask_filter_table_tb;
  import ipf_pkg::*;

  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam int SEGMENTS  = 12;
  localparam int SEG_ITEMS = 146;
  localparam int DIRECTED_ROWS = 26;

  typedef struct packed {
    logic is_cfg;
    logic cfg_value;
    logic typed;
    req_t req;
    rsp_t rsp;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic result_valid_o;
  rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_wdata_i;

  logic [ADDR_W-1:0] rule_mask [MAX_ENTRIES];
  logic [ADDR_W-1:0] rule_value [MAX_ENTRIES];
  int                rule_count;
  logic              ban_on_match;
  rsp_t              pending_rsp [$];
  int                error_count;
  int                sender_idle_pct;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, 1'b0, 1'b1, '{REQ_LOOKUP, 32'h0000_0000}, '{1'b0, STATUS_DONE, 7'd0}},
    '{1'b0, 1'b0, 1'b1, '{REQ_REMOVE, 32'h0100_000a}, '{1'b0, STATUS_NOT_FOUND, 7'd0}},
    '{1'b0, 1'b0, 1'b1, '{REQ_RESERVED, 32'hffff_ffff}, '{1'b0, STATUS_DONE, 7'd0}},
    '{1'b0, 1'b0, 1'b0, '{REQ_ADD, 32'h0100_000a}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h0133_7f0a}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h0100_000b}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_ADD, 32'hffff_ffff}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'hffff_ffff}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'hffff_fffe}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_ADD, 32'h0000_a8c0}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'hffff_ffff}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h1234_a8c0}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_RESERVED, 32'h0000_0000}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_REMOVE, 32'h0000_a8c0}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_REMOVE, 32'h0000_a8c0}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_ADD, 32'h0000_0000}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h5a5a_5a5a}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_REMOVE, 32'h0000_0000}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_REMOVE, 32'h0100_000a}, '0},
    '{1'b0, 1'b0, 1'b1, '{REQ_LOOKUP, 32'hffff_ffff}, '{1'b0, STATUS_DONE, 7'd0}},
    '{1'b1, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h0000_0000}, '0},
    '{1'b0, 1'b0, 1'b1, '{REQ_LOOKUP, 32'h0000_0000}, '{1'b1, STATUS_DONE, 7'd0}},
    '{1'b0, 1'b0, 1'b0, '{REQ_ADD, 32'h8000_0000}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h80ff_ffff}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_LOOKUP, 32'h7fff_ffff}, '0},
    '{1'b0, 1'b0, 1'b0, '{REQ_REMOVE, 32'h8000_0000}, '0}
  };

  ip_mask_filter_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL ip_mask_filter_table");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] octet_mask(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] m;
    int k;
    for (k = 0; k < ADDR_W / 8; k++) begin
      m[8*k +: 8] = {8{|a[8*k +: 8]}};
    end
    return m;
  endfunction

  function automatic rsp_t filter_predict(input req_t r);
    rsp_t              rsp;
    logic [ADDR_W-1:0] m;
    logic [ADDR_W-1:0] v;
    logic              hit;
    int                i;
    int                slot;
    rsp = '0;
    m = octet_mask(r.address);
    v = r.address & m;
    case (r.req_type)
      REQ_LOOKUP: begin
        hit = 1'b0;
        for (i = 0; i < rule_count; i++) begin
          if ((r.address & rule_mask[i]) == rule_value[i]) hit = 1'b1;
        end
        rsp.reject = hit ? ban_on_match : ~ban_on_match;
      end
      REQ_ADD: begin
        slot = rule_count;
        for (i = rule_count - 1; i >= 0; i--) begin
          if (rule_value[i] == '1) slot = i;
        end
        if (slot == rule_count && rule_count == MAX_ENTRIES) begin
          rsp.status = STATUS_FULL;
        end else begin
          rule_mask[slot] = m;
          rule_value[slot] = v;
          if (slot == rule_count) rule_count++;
        end
      end
      REQ_REMOVE: begin
        slot = rule_count;
        for (i = rule_count - 1; i >= 0; i--) begin
          if (rule_mask[i] == m && rule_value[i] == v) slot = i;
        end
        if (slot == rule_count) begin
          rsp.status = STATUS_NOT_FOUND;
        end else begin
          for (i = slot + 1; i < rule_count; i++) begin
            rule_mask[i-1] = rule_mask[i];
            rule_value[i-1] = rule_value[i];
          end
          rule_count--;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_total = TOTAL_W'(rule_count);
    return rsp;
  endfunction

  // Removes and lookups are steered toward entries in use so that hits are common.
  function automatic req_t draw_request(input int bias);
    req_t r;
    int   pick;
    int   add_cut;
    int   rem_cut;
    int   slot;
    int   k;
    case (bias)
      0: begin
        add_cut = 70;
        rem_cut = 80;
      end
      1: begin
        add_cut = 33;
        rem_cut = 60;
      end
      default: begin
        add_cut = 18;
        rem_cut = 78;
      end
    endcase
    pick = $urandom_range(99);
    r.address = $urandom;
    for (k = 0; k < ADDR_W / 8; k++) begin
      if ($urandom_range(99) < 30) r.address[8*k +: 8] = 8'h00;
    end
    if (pick < 3) begin
      r.req_type = REQ_RESERVED;
    end else if (pick < add_cut) begin
      r.req_type = REQ_ADD;
      if ($urandom_range(9) == 0) r.address = '1;
    end else if (pick < rem_cut) begin
      r.req_type = REQ_REMOVE;
      if (rule_count != 0 && $urandom_range(3) != 0) begin
        r.address = rule_value[$urandom_range(rule_count - 1)];
      end
    end else begin
      r.req_type = REQ_LOOKUP;
      if (rule_count != 0 && $urandom_range(1) == 1) begin
        slot = $urandom_range(rule_count - 1);
        r.address = rule_value[slot] | ($urandom & ~rule_mask[slot]);
        if ($urandom_range(7) == 0) r.address = r.address ^ (32'h1 << $urandom_range(31));
      end
    end
    return r;
  endfunction

  task automatic issue_request(input req_t r, input logic typed, input rsp_t typed_rsp);
    rsp_t predicted;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    predicted = filter_predict(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ban_mode(input logic mode);
    wait_for_results();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ban_on_match = mode;
  endtask

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, got reject %0d status %0d total %0d", $time,
                 rsp_o.reject, rsp_o.status, rsp_o.entry_total);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.reject !== want.reject) begin
          error_count++;
          $display("%0t: reject mismatch, expected %0d, got %0d", $time,
                   want.reject, rsp_o.reject);
        end
        if (rsp_o.status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time,
                   want.status, rsp_o.status);
        end
        if (rsp_o.entry_total !== want.entry_total) begin
          error_count++;
          $display("%0t: entry_total mismatch, expected %0d, got %0d", $time,
                   want.entry_total, rsp_o.entry_total);
        end
      end
    end
  end

  initial begin : stimulus
    int row;
    int seg;
    int n;
    int issued;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_wdata_i <= 1'b0;
    for (n = 0; n < MAX_ENTRIES; n++) begin
      rule_mask[n] = '0;
      rule_value[n] = '0;
    end
    rule_count = 0;
    ban_on_match = 1'b1;
    error_count = 0;
    sender_idle_pct = 30;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (directed_rows[row].is_cfg) begin
        write_ban_mode(directed_rows[row].cfg_value);
      end else begin
        issue_request(directed_rows[row].req, directed_rows[row].typed,
                      directed_rows[row].rsp);
      end
    end

    issued = 0;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_ban_mode(seg[0]);
      for (n = 0; n < SEG_ITEMS; n++) begin
        if (issued < SEGMENTS * SEG_ITEMS / 3) begin
          sender_idle_pct = 30;
        end else if (issued < 2 * SEGMENTS * SEG_ITEMS / 3) begin
          sender_idle_pct = 51;
        end else begin
          sender_idle_pct = 0;
        end
        issue_request(draw_request(seg % 3), 1'b0, '0);
        issued++;
      end
    end

    wait_for_results();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS ip_mask_filter_table");
    end else begin
      $display("FAIL ip_mask_filter_table");
    end
    $finish;
  end

endmodule
